>>> design/assert_macros.svh
// Assertion macros used by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, skipped while rst is high.
`define NSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond at one edge implies prop at the next edge.
`define NSC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> design/nsc_pkg.sv
// Types, character codes and hex decoding for the sentence checker.
package nsc_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_F   = 8'h46;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;
   localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_ID     = 5'b00010,
      PH_FIELDS = 5'b00100,
      PH_HEX1   = 5'b01000,
      PH_HEX2   = 5'b10000
   } phase_type;

   // Registered input character handed to the sentence core.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } in_item_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_digit_type;

   // Nibble of a hex digit; a non-digit gives ok low and nibble zero.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.ok     = 1'b0;
      d.nibble = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.ok     = 1'b1;
         d.nibble = c[3:0];
      end else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) ||
                   (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
         d.ok     = 1'b1;
         d.nibble = c[3:0] + HEX_LETTER_OFFSET;
      end
      return d;
   endfunction

endpackage

>>> design/nsc_channel_if.sv
// Valid/ready channel interfaces for received characters and check results.
interface nsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface nsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        checksum_ok;
   logic        hex_error;
   logic [7:0]  field_count;
   logic [47:0] sentence_id;
   logic [7:0]  received_checksum;
   logic [7:0]  computed_checksum;

   modport source (output valid, output checksum_ok, output hex_error,
                   output field_count, output sentence_id,
                   output received_checksum, output computed_checksum,
                   input ready);
   modport sink   (input valid, input checksum_ok, input hex_error,
                   input field_count, input sentence_id,
                   input received_checksum, input computed_checksum,
                   output ready);
endinterface

>>> design/nmea_sentence_checker.sv
// Top level of the NMEA sentence checksum checker.
//
// Takes one received character per transaction on req_if and returns one
// result on rsp_if for each complete sentence: '$', body, '*', two hex digits.
// A character is accepted in every cycle except while the stall below holds;
// it passes to the result port through the input register, then the sentence
// state and result register. The only stall is a character that
// completes a sentence while the previous result still waits in the result
// register; the input register then holds it until rsp_if is taken. A '$'
// restarts the sentence at any point and drops the one in progress without a
// result. Characters outside a sentence are ignored. The body bytes between
// '$' and '*' are XORed into the computed checksum, commas are counted up to
// 255, and the first ID_CHARS identifier characters are kept with the first
// one in byte ID_CHARS-1 of sentence_id (masked to 48 bits). A non-hex digit
// after '*' reads as zero, sets hex_error and clears checksum_ok. There is no
// memory and no clearing pass after reset.
module nmea_sentence_checker #(
   parameter int ID_CHARS = 6
) (
   input  logic       clock,
   input  logic       reset,
   nsc_req_if.sink    req_if,
   nsc_rsp_if.source  rsp_if
);

   // Registered character and the hand-off back to the input stage.
   nsc_pkg::in_item_type item;
   logic                 consume;

   // Hold one received character until the core takes it.
   nsc_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .consume (consume),
      .item    (item)
   );

   // Advance the sentence state and load a result on the second hex digit.
   nsc_sentence_core #(
      .ID_CHARS (ID_CHARS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .consume (consume),
      .rsp_if  (rsp_if)
   );

endmodule

>>> design/nsc_input_stage.sv
// Input register: captures one character per transaction.
module nsc_input_stage (
   input  logic                clock,
   input  logic                reset,
   nsc_req_if.sink             req_if,
   input  logic                consume,
   output nsc_pkg::in_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       accept;

   assign req_if.ready = !valid_ff || consume;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_if.in_byte;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

>>> design/nsc_sentence_core.sv
// Sentence state, checksum and identifier update, and the result register.
`include "assert_macros.svh"

module nsc_sentence_core #(
   parameter int ID_CHARS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  nsc_pkg::in_item_type item,
   output logic                consume,
   nsc_rsp_if.source           rsp_if
);

   localparam int ID_W  = ID_CHARS * 8;
   localparam int LEN_W = $clog2(ID_CHARS + 1);

   nsc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       count_ff, count_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [3:0]       high_ff, high_in;
   logic             bad_ff, bad_in;

   logic        out_valid_ff, out_valid_in;
   logic        ok_ff, ok_in;
   logic        hexerr_ff, hexerr_in;
   logic [7:0]  fields_ff, fields_in;
   logic [47:0] sid_ff, sid_in;
   logic [7:0]  rx_ff, rx_in;
   logic [7:0]  calc_ff, calc_in;

   logic                   is_dollar;
   logic                   produces;
   logic                   out_free;
   nsc_pkg::hex_digit_type digit;
   logic [3:0]             nibble;
   logic                   digit_bad;
   logic [ID_W+47:0]       id_wide;

   assign is_dollar = (item.data == nsc_pkg::CHAR_DOLLAR);
   assign produces  = item.valid && !is_dollar && (phase_ff == nsc_pkg::PH_HEX2);
   assign out_free  = !out_valid_ff || rsp_if.ready;
   // Stall only a character that completes a sentence while the result is held.
   assign consume   = item.valid && (!produces || out_free);

   assign digit     = nsc_pkg::hex_decode(item.data);
   assign nibble    = digit.ok ? digit.nibble : 4'd0;
   assign digit_bad = !digit.ok;
   assign id_wide   = {48'd0, id_ff};

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      count_in = count_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      high_in  = high_ff;
      bad_in   = bad_ff;
      if (consume) begin
         if (is_dollar) begin
            phase_in = nsc_pkg::PH_ID;
            xor_in   = 8'd0;
            count_in = 8'd0;
            id_in    = '0;
            len_in   = '0;
            high_in  = 4'd0;
            bad_in   = 1'b0;
         end else begin
            case (phase_ff)
               nsc_pkg::PH_ID, nsc_pkg::PH_FIELDS: begin
                  if (item.data == nsc_pkg::CHAR_STAR) begin
                     phase_in = nsc_pkg::PH_HEX1;
                  end else begin
                     xor_in = xor_ff ^ item.data;
                     if (item.data == nsc_pkg::CHAR_COMMA) begin
                        if (count_ff != nsc_pkg::COUNT_MAX) begin
                           count_in = count_ff + 8'd1;
                        end
                        phase_in = nsc_pkg::PH_FIELDS;
                     end else if (phase_ff == nsc_pkg::PH_ID &&
                                  len_ff < LEN_W'(ID_CHARS)) begin
                        // First character lands in the top byte.
                        for (int k = 0; k < ID_CHARS; k++) begin
                           if (len_ff == LEN_W'(ID_CHARS - 1 - k)) begin
                              id_in[k*8 +: 8] = item.data;
                           end
                        end
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
               end
               nsc_pkg::PH_HEX1: begin
                  high_in  = nibble;
                  bad_in   = bad_ff | digit_bad;
                  phase_in = nsc_pkg::PH_HEX2;
               end
               nsc_pkg::PH_HEX2: begin
                  phase_in = nsc_pkg::PH_IDLE;
               end
               default: begin
                  phase_in = nsc_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      ok_in        = ok_ff;
      hexerr_in    = hexerr_ff;
      fields_in    = fields_ff;
      sid_in       = sid_ff;
      rx_in        = rx_ff;
      calc_in      = calc_ff;
      if (produces && consume) begin
         out_valid_in = 1'b1;
         hexerr_in    = bad_ff | digit_bad;
         rx_in        = {high_ff, nibble};
         ok_in        = !(bad_ff | digit_bad) && ({high_ff, nibble} == xor_ff);
         fields_in    = count_ff;
         sid_in       = id_wide[47:0];
         calc_in      = xor_ff;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= nsc_pkg::PH_IDLE;
         xor_ff       <= 8'd0;
         count_ff     <= 8'd0;
         id_ff        <= '0;
         len_ff       <= '0;
         high_ff      <= 4'd0;
         bad_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         xor_ff       <= xor_in;
         count_ff     <= count_in;
         id_ff        <= id_in;
         len_ff       <= len_in;
         high_ff      <= high_in;
         bad_ff       <= bad_in;
         out_valid_ff <= out_valid_in;
      end
      ok_ff     <= ok_in;
      hexerr_ff <= hexerr_in;
      fields_ff <= fields_in;
      sid_ff    <= sid_in;
      rx_ff     <= rx_in;
      calc_ff   <= calc_in;
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.checksum_ok       = ok_ff;
   assign rsp_if.hex_error         = hexerr_ff;
   assign rsp_if.field_count       = fields_ff;
   assign rsp_if.sentence_id       = sid_ff;
   assign rsp_if.received_checksum = rx_ff;
   assign rsp_if.computed_checksum = calc_ff;

   `NSC_ASSERT(a_ok_consistent, clock, reset, !(out_valid_ff && ok_ff) || (!hexerr_ff && rx_ff == calc_ff), "checksum_ok set with bad hex or mismatch")
   `NSC_ASSERT(a_stall_only_when_full, clock, reset, !(item.valid && !consume) || (out_valid_ff && !rsp_if.ready && phase_ff == nsc_pkg::PH_HEX2), "input stalled without a held result")
   `NSC_ASSERT_NEXT(a_result_closes_sentence, clock, reset, produces && consume, phase_ff == nsc_pkg::PH_IDLE && out_valid_ff, "result did not close the sentence")

endmodule
